// File: rtl/wtb_pkg.sv
package wtb_pkg;

    // Table geometry
    localparam int TABLE_SIZE   = 512;
    localparam int OCTAVE_COUNT = 10;
    localparam int MOD_M        = TABLE_SIZE - 1;
    localparam int RAW_DEPTH    = OCTAVE_COUNT * TABLE_SIZE;
    localparam int RAW_AW       = $clog2(RAW_DEPTH);
    localparam int RES_W        = $clog2(MOD_M);
    localparam int TBL_W        = $clog2(TABLE_SIZE);
    localparam int OCT_IW       = (OCTAVE_COUNT > 1) ? $clog2(OCTAVE_COUNT) : 1;

    // Datapath widths
    localparam int TRIG_W = 22;
    localparam int DIV_NW = 57;

    // Phase of residue r is floor(r * 2^32 / MOD_M), walked by quotient and remainder
    localparam longint unsigned PH_FULL = 64'h1_0000_0000;
    localparam logic [31:0]      PH_STEP = 32'(PH_FULL / MOD_M);
    localparam logic [RES_W-1:0] PH_REM  = RES_W'(PH_FULL % MOD_M);

    typedef enum logic [1:0] {
        WAVE_SAW,
        WAVE_SQUARE,
        WAVE_TRIANGLE,
        WAVE_SINE
    } t_wave;

    localparam logic [1:0] CFG_WAVEFORM  = 2'd0;
    localparam logic [1:0] CFG_BASE_FREQ = 2'd1;
    localparam logic [1:0] CFG_NYQUIST   = 2'd2;

    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_BUILT = 2'd1;
    localparam logic [1:0] STATUS_RANGE     = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [3:0] octave;
        logic [8:0] sample_index;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_MEM,
        S_RD_MUL,
        S_WCLR,
        S_HINIT,
        S_HD,
        S_HCHK,
        S_HDIV,
        S_HWR,
        S_TSTART,
        S_TRUN,
        S_TWAIT,
        S_CPRD,
        S_CPWR,
        S_JINIT,
        S_MAC,
        S_DRAIN,
        S_STORE,
        S_RCPS,
        S_RCP,
        S_FIN
    } t_state;

endpackage

// File: rtl/wtb_in_if.sv
interface wtb_in_if
    import wtb_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/wtb_out_if.sv
interface wtb_out_if
    import wtb_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/bandlimited_wavetable_builder_top.sv
// Channel  | Dir | Payload                          | Transfer when
// i_in     | in  | opcode, octave, sample_index     | i_in.valid && i_in.ready
// o_out    | out | sample (Q1.15), status           | o_out.valid && o_out.ready
// i_cfg_*  | in  | index 0..2, data up to 24 bits   | i_cfg_we
//
// A read result passes the store read, the scale multiply and the finish step in turn.
// A build clears the weights, walks the harmonics through the shared divider, fills
// the sine table from the iterative sine unit, sums (one multiply-accumulate a cycle)
// and takes the reciprocal divide; a pure sine build skips the harmonics and sums.
// Reset clears control state and the built flags and loads the default configuration only; no clearing pass.
// Input is taken only in idle; a held result stalls the finish step, not acceptance.
module bandlimited_wavetable_builder_top
    import wtb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    wtb_in_if.sink      i_in,
    wtb_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    // Control and configuration
    t_state      r_state, n_state;
    logic [1:0]  r_wave;
    logic [15:0] r_base;
    logic [23:0] r_nyq;
    logic [OCTAVE_COUNT-1:0] r_built;
    logic [31:0] r_recip [OCTAVE_COUNT];
    logic [OCT_IW-1:0] r_oct;
    t_out_item   r_res;
    t_out_item   r_out;
    logic        r_out_valid;

    // Harmonic walk
    logic [24:0]      r_k;
    logic [RES_W-1:0] r_hres;
    logic [39:0]      r_kf;
    logic [49:0]      r_d;

    // Residue, phase and sample counters
    logic [RES_W-1:0] r_r;
    logic [RES_W-1:0] r_idx;
    logic [31:0]      r_ph;
    logic [RES_W-1:0] r_rm;
    logic [TBL_W-1:0] r_j;

    // Multiply-accumulate pipeline
    logic               r_p1;
    logic               r_p2;
    logic signed [54:0] r_prod;
    logic signed [63:0] r_acc;
    logic [31:0]        r_peak;

    // Read scaling
    logic [63:0] r_rdprod;
    logic        r_rdneg;

    // Memory ports
    logic              raw_we, raw_re;
    logic [RAW_AW-1:0] raw_waddr, raw_raddr;
    logic [31:0]       raw_wdata, raw_rdata;
    logic              w_we, w_re;
    logic [RES_W-1:0]  w_waddr, w_raddr;
    logic [31:0]       w_wdata, w_rdata;
    logic              t_we, t_re;
    logic [RES_W-1:0]  t_waddr, t_raddr;
    logic [TRIG_W-1:0] t_wdata, t_rdata;

    // Shared units
    logic              div_start, div_done;
    logic [DIV_NW-1:0] div_dividend, div_quot;
    logic [31:0]       div_divisor;
    logic              sin_start, sin_done;
    logic [31:0]       sin_phase;
    logic signed [TRIG_W-1:0] sin_value;

    // Decode and datapath terms
    logic              in_xfer;
    logic              in_range;
    logic [OCT_IW-1:0] in_oidx;
    logic              in_built;
    logic [31:0]       f_base;
    logic              step2;
    logic              harm_ok;
    logic [RES_W-1:0]  stepj;
    logic [RES_W:0]    idx_sum, hres_sum, rm_sum;
    logic [RES_W-1:0]  idx_nxt, hres_nxt;
    logic              rm_wrap;
    logic              last_r, last_j;
    logic signed [63:0] acc_s;
    logic [63:0]       acc_mag;
    logic [41:0]       mag_r;
    logic [31:0]       v_word;
    logic [31:0]       v_mag;
    logic [31:0]       rd_mag;
    logic [22:0]       rd_q;
    logic [15:0]       rd_sample;
    logic [31:0]       recip_sat;
    logic [RAW_AW-1:0] build_addr;

    wtb_ram #(.DEPTH(RAW_DEPTH), .WIDTH(32)) u_raw (
        .i_clk   (i_clk),
        .i_we    (raw_we),
        .i_waddr (raw_waddr),
        .i_wdata (raw_wdata),
        .i_re    (raw_re),
        .i_raddr (raw_raddr),
        .o_rdata (raw_rdata)
    );

    wtb_ram #(.DEPTH(MOD_M), .WIDTH(32)) u_weight (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    wtb_ram #(.DEPTH(MOD_M), .WIDTH(TRIG_W)) u_trig (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_re    (t_re),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    wtb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    wtb_sine u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sin_start),
        .i_phase (sin_phase),
        .o_done  (sin_done),
        .o_value (sin_value)
    );

    always_comb begin
        in_xfer  = i_in.valid && i_in.ready;
        in_range = {1'b0, i_in.data.octave} < 5'(OCTAVE_COUNT);
        in_oidx  = i_in.data.octave[OCT_IW-1:0];
        in_built = r_built[in_oidx];

        // Harmonic k is kept while k * f stays below the cutoff and its weight is nonzero
        f_base  = 32'(r_base) << r_oct;
        step2   = r_wave != WAVE_SAW;
        harm_ok = (r_base != 16'd0) && (r_kf < 40'(r_nyq)) && (r_d <= 50'h0_8000_0000);

        hres_sum = (RES_W+1)'(r_hres) + (step2 ? (RES_W+1)'(2) : (RES_W+1)'(1));
        hres_nxt = (hres_sum >= (RES_W+1)'(MOD_M)) ? RES_W'(hres_sum - (RES_W+1)'(MOD_M))
                                                   : RES_W'(hres_sum);

        // Sample j uses residue step j mod M; the last sample wraps to zero
        stepj   = (32'(r_j) == MOD_M) ? '0 : RES_W'(r_j);
        idx_sum = (RES_W+1)'(r_idx) + (RES_W+1)'(stepj);
        idx_nxt = (idx_sum >= (RES_W+1)'(MOD_M)) ? RES_W'(idx_sum - (RES_W+1)'(MOD_M))
                                                 : RES_W'(idx_sum);

        rm_sum  = (RES_W+1)'(r_rm) + (RES_W+1)'(PH_REM);
        rm_wrap = rm_sum >= (RES_W+1)'(MOD_M);

        last_r = r_r == RES_W'(MOD_M - 1);
        last_j = r_j == TBL_W'(TABLE_SIZE - 1);

        // Round the sum half away from zero to Q3.28 and saturate
        acc_s   = (r_wave == WAVE_SAW) ? -r_acc : r_acc;
        acc_mag = acc_s[63] ? 64'(-acc_s) : 64'(acc_s);
        mag_r   = 42'((acc_mag + 64'h20_0000) >> 22);
        if (acc_s[63]) begin
            v_mag  = (mag_r > 42'h0_8000_0000) ? 32'h8000_0000 : mag_r[31:0];
            v_word = -v_mag;
        end else begin
            v_mag  = (mag_r > 42'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag_r[31:0];
            v_word = v_mag;
        end

        rd_mag = raw_rdata[31] ? -raw_rdata : raw_rdata;
        rd_q   = 23'((r_rdprod + 64'h100_0000_0000) >> 41);
        if (r_rdneg) begin
            rd_sample = (rd_q > 23'd32768) ? 16'h8000 : 16'(-rd_q);
        end else begin
            rd_sample = (rd_q > 23'd32767) ? 16'h7FFF : rd_q[15:0];
        end

        recip_sat  = (div_quot[DIV_NW-1:32] != '0) ? 32'hFFFF_FFFF : div_quot[31:0];
        build_addr = RAW_AW'(r_oct) * RAW_AW'(TABLE_SIZE) + RAW_AW'(r_j);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (!in_range) begin
                        n_state = S_FIN;
                    end else if (i_in.data.opcode == OP_BUILD) begin
                        n_state = (r_wave == WAVE_SINE) ? S_TSTART : S_WCLR;
                    end else if (!in_built) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_RD_MEM;
                    end
                end
            end
            S_RD_MEM: n_state = S_RD_MUL;
            S_RD_MUL: n_state = S_FIN;
            S_WCLR: begin
                if (last_r) begin
                    n_state = S_HINIT;
                end
            end
            S_HINIT: n_state = S_HD;
            S_HD:    n_state = S_HCHK;
            S_HCHK:  n_state = harm_ok ? S_HDIV : S_TSTART;
            S_HDIV: begin
                if (div_done) begin
                    n_state = S_HWR;
                end
            end
            S_HWR:    n_state = S_HD;
            S_TSTART: n_state = S_TRUN;
            S_TRUN:   n_state = S_TWAIT;
            S_TWAIT: begin
                if (sin_done) begin
                    if (!last_r) begin
                        n_state = S_TRUN;
                    end else begin
                        n_state = (r_wave == WAVE_SINE) ? S_CPRD : S_JINIT;
                    end
                end
            end
            S_CPRD: n_state = S_CPWR;
            S_CPWR: n_state = last_j ? S_FIN : S_CPRD;
            S_JINIT: n_state = S_MAC;
            S_MAC: begin
                if (last_r) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_p1 && !r_p2) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: n_state = last_j ? S_RCPS : S_JINIT;
            S_RCPS:  n_state = (r_peak == 32'd0) ? S_FIN : S_RCP;
            S_RCP: begin
                if (div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory, unit and handshake controls
    always_comb begin
        i_in.ready   = r_state == S_IDLE;
        raw_we       = 1'b0;
        raw_waddr    = build_addr;
        raw_wdata    = v_word;
        raw_re       = 1'b0;
        raw_raddr    = RAW_AW'(in_oidx) * RAW_AW'(TABLE_SIZE)
                     + RAW_AW'(32'(i_in.data.sample_index) % TABLE_SIZE);
        w_we         = 1'b0;
        w_waddr      = r_r;
        w_wdata      = '0;
        w_re         = 1'b0;
        w_raddr      = r_r;
        t_we         = 1'b0;
        t_waddr      = r_r;
        t_wdata      = sin_value;
        t_re         = 1'b0;
        t_raddr      = r_idx;
        div_start    = 1'b0;
        div_dividend = DIV_NW'(64'h4000_0000) + DIV_NW'(r_d >> 1);
        div_divisor  = r_d[31:0];
        sin_start    = 1'b0;
        sin_phase    = r_ph + ((r_wave == WAVE_TRIANGLE) ? 32'h4000_0000 : 32'd0);
        case (r_state)
            S_IDLE: begin
                raw_re = in_xfer && in_range && (i_in.data.opcode == OP_READ) && in_built;
            end
            S_WCLR: begin
                w_we = 1'b1;
            end
            S_HCHK: begin
                div_start = harm_ok;
                w_re      = harm_ok;
                w_raddr   = r_hres;
            end
            S_HWR: begin
                w_we    = 1'b1;
                w_waddr = r_hres;
                w_wdata = w_rdata + div_quot[31:0];
            end
            S_TRUN: begin
                sin_start = 1'b1;
            end
            S_TWAIT: begin
                t_we = sin_done;
            end
            S_CPRD: begin
                t_re    = 1'b1;
                t_raddr = stepj;
            end
            S_CPWR: begin
                raw_we    = 1'b1;
                raw_wdata = 32'($signed(t_rdata)) <<< 8;
            end
            S_MAC: begin
                w_re = 1'b1;
                t_re = 1'b1;
            end
            S_STORE: begin
                raw_we = 1'b1;
            end
            S_RCPS: begin
                div_start    = r_peak != 32'd0;
                div_dividend = DIV_NW'(64'h0100_0000_0000_0000) + DIV_NW'(r_peak >> 1);
                div_divisor  = r_peak;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration, built flags, output register and accumulate pipeline flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave      <= WAVE_SAW;
            r_base      <= 16'd320;
            r_nyq       <= 24'd352800;
            r_built     <= '0;
            r_out_valid <= 1'b0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WAVEFORM:  r_wave <= i_cfg_data[1:0];
                    CFG_BASE_FREQ: r_base <= i_cfg_data[15:0];
                    CFG_NYQUIST:   r_nyq  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if ((r_state == S_CPWR && last_j) || (r_state == S_RCPS && r_peak == 32'd0)
                    || (r_state == S_RCP && div_done)) begin
                r_built[r_oct] <= 1'b1;
            end
            // Load a new result on finish, drop the held one once taken
            if (r_state == S_FIN && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_p1 <= r_state == S_MAC;
            r_p2 <= r_p1;
        end
    end

    // Build and read datapath
    always_ff @(posedge i_clk) begin
        if (r_p1) begin
            r_prod <= $signed({1'b0, w_rdata}) * $signed(t_rdata);
        end
        if (r_state == S_JINIT) begin
            r_acc <= '0;
        end else if (r_p2) begin
            r_acc <= r_acc + 64'(r_prod);
        end
        if (r_state == S_FIN && (!r_out_valid || o_out.ready)) begin
            r_out <= r_res;
        end
        case (r_state)
            S_IDLE: begin
                r_oct        <= in_oidx;
                r_r          <= '0;
                r_res.sample <= '0;
                if (!in_range) begin
                    r_res.status <= STATUS_RANGE;
                end else if (i_in.data.opcode == OP_READ && !in_built) begin
                    r_res.status <= STATUS_NOT_BUILT;
                end else begin
                    r_res.status <= STATUS_OK;
                end
            end
            S_RD_MEM: begin
                r_rdprod <= 64'(rd_mag) * 64'(r_recip[r_oct]);
                r_rdneg  <= raw_rdata[31];
            end
            S_RD_MUL: begin
                r_res.sample <= rd_sample;
            end
            S_WCLR: begin
                r_r <= r_r + 1'b1;
            end
            S_HINIT: begin
                r_k    <= 25'd1;
                r_hres <= RES_W'(1);
                r_kf   <= 40'(f_base);
            end
            S_HD: begin
                r_d <= (r_wave == WAVE_TRIANGLE) ? 50'(r_k) * 50'(r_k) : 50'(r_k);
            end
            S_HWR: begin
                // Advance to the next harmonic and its residue
                r_k    <= r_k + (step2 ? 25'd2 : 25'd1);
                r_hres <= hres_nxt;
                r_kf   <= r_kf + (step2 ? 40'(f_base) << 1 : 40'(f_base));
            end
            S_TSTART: begin
                r_r    <= '0;
                r_ph   <= '0;
                r_rm   <= '0;
                r_j    <= '0;
                r_peak <= '0;
            end
            S_TWAIT: begin
                if (sin_done) begin
                    r_r  <= r_r + 1'b1;
                    r_ph <= r_ph + PH_STEP + 32'(rm_wrap);
                    r_rm <= rm_wrap ? RES_W'(rm_sum - (RES_W+1)'(MOD_M)) : RES_W'(rm_sum);
                end
            end
            S_CPWR: begin
                r_j <= r_j + 1'b1;
                if (last_j) begin
                    r_recip[r_oct] <= 32'h1000_0000;
                end
            end
            S_JINIT: begin
                r_r   <= '0;
                r_idx <= '0;
            end
            S_MAC: begin
                r_r   <= r_r + 1'b1;
                r_idx <= idx_nxt;
            end
            S_STORE: begin
                r_j <= r_j + 1'b1;
                if (v_mag > r_peak) begin
                    r_peak <= v_mag;
                end
            end
            S_RCPS: begin
                if (r_peak == 32'd0) begin
                    r_recip[r_oct] <= 32'hFFFF_FFFF;
                end
            end
            S_RCP: begin
                if (div_done) begin
                    r_recip[r_oct] <= recip_sat;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef ASSERT_OFF
    a_store_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STORE) |-> (!r_p1 && !r_p2))
        else $error("sum stored before the accumulate pipeline drained");

    a_raw_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        raw_we |-> (r_state == S_STORE || r_state == S_CPWR))
        else $error("table store written outside a build");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result loaded outside the finish step");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");
`endif

endmodule

// File: rtl/wtb_ram.sv
module wtb_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/wtb_div.sv
module wtb_div
    import wtb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [31:0]       i_divisor,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quot
);

    localparam int CW = $clog2(DIV_NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [31:0]       r_div;
    logic [31:0]       r_rem;
    logic [DIV_NW-1:0] r_quo;

    logic [32:0] rem_sh;
    logic        fits;
    logic [32:0] rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_NW-1]};
        fits    = rem_sh >= {1'b0, r_div};
        rem_sub = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Restoring division, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[31:0] : rem_sh[31:0];
            r_quo <= {r_quo[DIV_NW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// File: rtl/wtb_sine.sv
module wtb_sine
    import wtb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [31:0]              i_phase,
    output logic                     o_done,
    output logic signed [TRIG_W-1:0] o_value
);

    localparam logic [2:0] LAST_STEP = 3'd6;

    function automatic logic [31:0] sin_coef(input logic [2:0] i);
        logic [31:0] c;
        case (i)
            3'd0:    c = 32'd172272;
            3'd1:    c = 32'd5026995;
            3'd2:    c = 32'd85569306;
            3'd3:    c = 32'd693598668;
            default: c = 32'd1686629713;
        endcase
        return c;
    endfunction

    logic                     r_busy;
    logic                     r_done;
    logic                     r_half;
    logic [2:0]               r_step;
    logic [1:0]               r_quad;
    logic [30:0]              r_x;
    logic [30:0]              r_x2;
    logic [31:0]              r_t;
    logic [62:0]              r_prod;
    logic signed [TRIG_W-1:0] r_value;

    logic [30:0] op_a;
    logic [31:0] op_b;
    logic [30:0] x_in;
    logic [32:0] y;
    logic [22:0] y_rnd;
    logic [20:0] y_sat;

    always_comb begin
        x_in = {1'b0, i_phase[29:0]};
        if (i_phase[30]) begin
            x_in = 31'h4000_0000 - {1'b0, i_phase[29:0]};
        end
        op_a = ((r_step == 3'd0) || (r_step == LAST_STEP)) ? r_x : r_x2;
        op_b = (r_step == 3'd0) ? {1'b0, r_x} : r_t;
        y     = 33'(r_prod >> 30);
        y_rnd = 23'((y + 33'd512) >> 10);
        y_sat = (y_rnd > 23'h10_0000) ? 21'h10_0000 : y_rnd[20:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_half <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_half <= 1'b0;
                r_step <= '0;
            end else if (r_busy) begin
                r_half <= !r_half;
                if (r_half) begin
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // Alternate one multiply and one polynomial update
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quad <= i_phase[31:30];
            r_x    <= x_in;
        end else if (r_busy) begin
            if (!r_half) begin
                r_prod <= 63'(op_a) * 63'(op_b);
            end else if (r_step == 3'd0) begin
                r_x2 <= 31'(r_prod >> 30);
                r_t  <= 32'd3864;
            end else if (r_step == LAST_STEP) begin
                r_value <= r_quad[1] ? -$signed({1'b0, y_sat}) : $signed({1'b0, y_sat});
            end else begin
                r_t <= sin_coef(r_step - 3'd1) - 32'(r_prod >> 30);
            end
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

// File: verif/bandlimited_wavetable_builder_top_tb.sv
`timescale 1ns / 100ps

module bandlimited_wavetable_builder_top_tb;
    import wtb_pkg::*;

    // A full-table build spends most of its time in the 512 x 511 sum,
    // so the stall limit covers one build several times over.
    localparam int unsigned STALL_LIMIT = 2_000_000;
    localparam int unsigned RANDOM_ITEMS = 600;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_data;

    wtb_in_if  in_ch ();
    wtb_out_if out_ch ();

    bandlimited_wavetable_builder_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow of the configuration registers
    t_wave       wave_cfg;
    logic [15:0] base_cfg;
    logic [23:0] nyq_cfg;

    // Shadow of the table store
    int          raw_tab [RAW_DEPTH];
    logic [31:0] recip_tab [OCTAVE_COUNT];
    bit          built_tab [OCTAVE_COUNT];

    t_in_item  pending_items[$];
    t_out_item expected_samples[$];

    int unsigned error_count = 0;
    int unsigned in_gap_left;
    int unsigned out_stall_left;
    int unsigned idle_cycles;
    bit          no_idle;

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    // Sine of 2*pi*u/2^32 in Q1.20, odd polynomial on a quarter turn
    function automatic int sine_q20(logic [31:0] u);
        longint unsigned x, x2, t, y;
        logic [1:0] quad;
        quad = u[31:30];
        x = u[29:0];
        if (quad[0]) x = (64'd1 << 30) - x;
        x2 = (x * x) >> 30;
        t = 3864;
        t = 172272 - ((x2 * t) >> 30);
        t = 5026995 - ((x2 * t) >> 30);
        t = 85569306 - ((x2 * t) >> 30);
        t = 693598668 - ((x2 * t) >> 30);
        t = 1686629713 - ((x2 * t) >> 30);
        y = (x * t) >> 30;
        y = (y + 512) >> 10;
        if (y > (64'd1 << 20)) y = 64'd1 << 20;
        return quad[1] ? -int'(y) : int'(y);
    endfunction

    function automatic logic [31:0] residue_phase(int unsigned p);
        longint unsigned w;
        w = longint'(p) << 32;
        return 32'(w / MOD_M);
    endfunction

    // Round half away from zero to Q3.28 and saturate to 32 bits
    function automatic int round_sum(longint x);
        longint unsigned mag;
        mag = (x < 0) ? longint'(-x) : longint'(x);
        mag = (mag + (64'd1 << 21)) >> 22;
        if (x < 0) begin
            if (mag > 64'd2147483648) mag = 64'd2147483648;
            return int'(-longint'(mag));
        end
        if (mag > 64'd2147483647) mag = 64'd2147483647;
        return int'(mag);
    endfunction

    task automatic build_table(int unsigned oct);
        longint          weights [MOD_M];
        int              trig [MOD_M];
        longint unsigned f, lim, k, d, peak, mag, q;
        int unsigned     stride, res, idx, stepj;
        longint          acc;
        int              v;
        logic [31:0]     ph;
        peak = 0;
        if (wave_cfg == WAVE_SINE) begin
            for (int j = 0; j < TABLE_SIZE; j++)
                raw_tab[oct * TABLE_SIZE + j] = sine_q20(residue_phase(j % MOD_M)) * 256;
            recip_tab[oct] = 32'd1 << 28;
            built_tab[oct] = 1'b1;
            return;
        end
        for (int r = 0; r < MOD_M; r++) weights[r] = 0;
        f = longint'(base_cfg) << oct;
        lim = 0;
        if (f != 0 && nyq_cfg != 0) lim = (longint'(nyq_cfg) - 1) / f;
        stride = (wave_cfg == WAVE_SAW) ? 1 : 2;
        k = 1;
        res = 1;
        while (k <= lim) begin
            d = (wave_cfg == WAVE_TRIANGLE) ? k * k : k;
            weights[res] += longint'(((64'd1 << 30) + d / 2) / d);
            k += stride;
            res += stride;
            if (res >= MOD_M) res -= MOD_M;
        end
        for (int r = 0; r < MOD_M; r++) begin
            ph = residue_phase(r);
            if (wave_cfg == WAVE_TRIANGLE) ph = ph + 32'h4000_0000;
            trig[r] = sine_q20(ph);
        end
        for (int j = 0; j < TABLE_SIZE; j++) begin
            acc = 0;
            idx = 0;
            stepj = j % MOD_M;
            for (int r = 0; r < MOD_M; r++) begin
                acc += weights[r] * longint'(trig[idx]);
                idx += stepj;
                if (idx >= MOD_M) idx -= MOD_M;
            end
            if (wave_cfg == WAVE_SAW) acc = -acc;
            v = round_sum(acc);
            raw_tab[oct * TABLE_SIZE + j] = v;
            mag = (v < 0) ? longint'(-longint'(v)) : longint'(v);
            if (mag > peak) peak = mag;
        end
        if (peak == 0) begin
            recip_tab[oct] = 32'hFFFF_FFFF;
        end else begin
            q = ((64'd1 << 56) + peak / 2) / peak;
            recip_tab[oct] = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        end
        built_tab[oct] = 1'b1;
    endtask

    function automatic logic signed [15:0] scaled_sample(int unsigned oct, int unsigned sidx);
        int              raw;
        longint unsigned mag, q;
        raw = raw_tab[oct * TABLE_SIZE + (sidx % TABLE_SIZE)];
        mag = (raw < 0) ? longint'(-longint'(raw)) : longint'(raw);
        q = (mag * longint'(recip_tab[oct]) + (64'd1 << 40)) >> 41;
        if (raw < 0) begin
            if (q > 32768) q = 32768;
            return 16'(-longint'(q));
        end
        if (q > 32767) q = 32767;
        return 16'(q);
    endfunction

    // Work out the result of one accepted command and update the shadow store
    task automatic predict_result(t_in_item cmd);
        t_out_item res;
        res.sample = '0;
        res.status = STATUS_OK;
        if (cmd.octave >= OCTAVE_COUNT) begin
            res.status = STATUS_RANGE;
        end else if (cmd.opcode == OP_BUILD) begin
            build_table(cmd.octave);
        end else if (!built_tab[cmd.octave]) begin
            res.status = STATUS_NOT_BUILT;
        end else begin
            res.sample = scaled_sample(cmd.octave, cmd.sample_index);
        end
        expected_samples.push_back(res);
    endtask

    // Mostly back-to-back, sometimes a short gap, rarely a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void queue_cmd(logic op, int unsigned oct, int unsigned sidx);
        t_in_item cmd;
        cmd.opcode = op;
        cmd.octave = 4'(oct);
        cmd.sample_index = 9'(sidx);
        pending_items.push_back(cmd);
    endfunction

    // Command driver: hold the item until transfer, then advance after a gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            in_gap_left <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) predict_result(in_ch.data);
            if (!in_ch.valid || in_ch.ready) begin
                if (in_gap_left != 0) begin
                    in_ch.valid <= 1'b0;
                    in_gap_left <= in_gap_left - 1;
                end else if (pending_items.size() != 0) begin
                    in_ch.data  <= pending_items.pop_front();
                    in_ch.valid <= 1'b1;
                    in_gap_left <= pick_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transfer against the oldest expected sample
    always @(posedge i_clk) begin
        t_out_item exp_res;
        int unsigned g;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_stall_left <= 0;
        end else if (out_ch.valid && out_ch.ready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected result sample=%0d status=%0d", $time,
                         out_ch.data.sample, out_ch.data.status);
                error_count++;
            end else begin
                exp_res = expected_samples.pop_front();
                if (exp_res.sample !== out_ch.data.sample) begin
                    $display("%0t: sample mismatch expected=%0d actual=%0d", $time,
                             exp_res.sample, out_ch.data.sample);
                    error_count++;
                end
                if (exp_res.status !== out_ch.data.status) begin
                    $display("%0t: status mismatch expected=%0d actual=%0d", $time,
                             exp_res.status, out_ch.data.status);
                    error_count++;
                end
            end
            g = pick_gap();
            out_ch.ready <= (g == 0);
            out_stall_left <= (g == 0) ? 0 : g - 1;
        end else if (out_stall_left != 0) begin
            out_ch.ready <= 1'b0;
            out_stall_left <= out_stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Watchdog: count cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Wait until every command is sent and answered, then let the pipeline drain
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_ch.valid || expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [23:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (index)
            CFG_WAVEFORM:  wave_cfg = t_wave'(value[1:0]);
            CFG_BASE_FREQ: base_cfg = value[15:0];
            CFG_NYQUIST:   nyq_cfg  = value;
            default: ;
        endcase
    endtask

    initial begin
        int unsigned r;
        int unsigned oct;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        no_idle     = 1'b0;
        wave_cfg    = WAVE_SAW;
        base_cfg    = 16'd320;
        nyq_cfg     = 24'd352800;
        for (int o = 0; o < OCTAVE_COUNT; o++) built_tab[o] = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Unbuilt and out-of-range octaves before anything is built
        queue_cmd(OP_READ, 0, 0);
        queue_cmd(OP_READ, 9, 511);
        queue_cmd(OP_READ, 15, 511);
        queue_cmd(OP_BUILD, 12, 0);
        queue_cmd(OP_READ, 10, 5);
        wait_drained();

        // Pure sine into every octave; these builds are short
        write_reg(CFG_WAVEFORM, 24'(WAVE_SINE));
        for (int o = 0; o < OCTAVE_COUNT; o++) queue_cmd(OP_BUILD, o, 0);
        queue_cmd(OP_READ, 0, 0);
        queue_cmd(OP_READ, 3, 128);
        queue_cmd(OP_READ, 9, 510);
        wait_drained();

        // Saw with two harmonics into octave 1
        write_reg(CFG_WAVEFORM, 24'(WAVE_SAW));
        write_reg(CFG_BASE_FREQ, 24'd65535);
        queue_cmd(OP_BUILD, 1, 0);
        queue_cmd(OP_READ, 1, 0);
        queue_cmd(OP_READ, 1, 511);
        queue_cmd(OP_READ, 1, 255);
        wait_drained();

        // Square at the top cutoff into octave 0
        write_reg(CFG_WAVEFORM, 24'(WAVE_SQUARE));
        write_reg(CFG_NYQUIST, 24'hFF_FFFF);
        queue_cmd(OP_BUILD, 0, 0);
        queue_cmd(OP_READ, 0, 1);
        queue_cmd(OP_READ, 0, 384);
        wait_drained();

        // Triangle with no harmonics below the cutoff: zero table, zero peak
        write_reg(CFG_WAVEFORM, 24'(WAVE_TRIANGLE));
        write_reg(CFG_BASE_FREQ, 24'd1);
        write_reg(CFG_NYQUIST, 24'd1);
        queue_cmd(OP_BUILD, 9, 0);
        queue_cmd(OP_READ, 9, 100);
        queue_cmd(OP_READ, 9, 511);
        wait_drained();

        // Random reads over all tables, sine rebuilds that spare octaves 0, 1 and 9
        write_reg(CFG_WAVEFORM, 24'(WAVE_SINE));
        for (int chunk = 0; chunk < 3; chunk++) begin
            no_idle = (chunk == 1);
            for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    oct = $urandom_range(0, 1) ? $urandom_range(2, 8) : $urandom_range(10, 15);
                    queue_cmd(OP_BUILD, oct, $urandom_range(0, 511));
                end else begin
                    oct = (r < 90) ? $urandom_range(0, OCTAVE_COUNT - 1) : $urandom_range(10, 15);
                    queue_cmd(OP_READ, oct, $urandom_range(0, 511));
                end
            end
            wait_drained();
            write_reg(CFG_BASE_FREQ, 24'($urandom_range(1, 65535)));
            write_reg(CFG_NYQUIST, 24'($urandom_range(1, 24'hFF_FFFF)));
        end
        no_idle = 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (error_count == 0 && expected_samples.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
